@@ design/tes_pkg.sv @@
// ----------------------------------------------------------------------------
// tes_pkg
// Shared constants, types and helpers of the truncated exponential sampler.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int WORD_W    = 32;
    localparam int QB        = 30;
    localparam int LOG_TERMS = 32;
    localparam int DIV_BITS  = 38;

    // Q.30 one, ln2 in Q.30, and saturation limit 32.0 for the decay exponent
    localparam logic [30:0] QONE      = 31'h4000_0000;
    localparam logic [29:0] LN2_Q     = 30'd744261118;
    localparam logic [35:0] A_SAT     = 36'h8_0000_0000;
    localparam logic [3:0]  EXP_TERMS = 4'd12;

    // configuration register indexes
    localparam logic [1:0] REG_MIN  = 2'd0;
    localparam logic [1:0] REG_MAX  = 2'd1;
    localparam logic [1:0] REG_RATE = 2'd2;

    // floor(2^30 / n) for n = 1..32
    localparam logic [30:0] RECIP_Q [1:32] = '{
        31'd1073741824, 31'd536870912, 31'd357913941, 31'd268435456,
        31'd214748364,  31'd178956970, 31'd153391689, 31'd134217728,
        31'd119304647,  31'd107374182, 31'd97612893,  31'd89478485,
        31'd82595524,   31'd76695844,  31'd71582788,  31'd67108864,
        31'd63161283,   31'd59652323,  31'd56512727,  31'd53687091,
        31'd51130563,   31'd48806446,  31'd46684427,  31'd44739242,
        31'd42949672,   31'd41297762,  31'd39768215,  31'd38347922,
        31'd37025580,   31'd35791394,  31'd34636833,  31'd33554432
    };

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SCALE,
        CS_REDUCE,
        CS_HMUL,
        CS_HDIV,
        CS_HFIX,
        CS_FINISH
    } cfg_state_t;

    typedef struct packed {
        logic        busy;
        logic        err;
        logic [31:0] min;
        logic [31:0] rate;
        logic [31:0] span;
        logic [30:0] one_minus_e;
    } cfg_view_t;

    // Fix a reciprocal quotient estimate that may be one low.
    function automatic logic [29:0] fix_quot(input logic [29:0] est,
                                             input logic [29:0] num,
                                             input logic [5:0]  div);
        logic [35:0] rem;
        rem = 36'(num) - 36'(est) * 36'(div);
        return est + 30'(rem >= 36'(div));
    endfunction

endpackage

@@ design/tes_cfg_unit.sv @@
// ----------------------------------------------------------------------------
// tes_cfg_unit
// Configuration registers and the per-configuration terms: span, error flag
// and 1 - e^(-rate*span), computed by a small sequencer after reset and each write.
// ----------------------------------------------------------------------------
module tes_cfg_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output tes_pkg::cfg_view_t view
);
    import tes_pkg::*;

    cfg_state_t  state_reg, state_next;
    logic [31:0] min_reg, min_next;
    logic [31:0] max_reg, max_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] span_reg, span_next;
    logic        err_reg, err_next;
    logic [35:0] a_reg, a_next;
    logic [5:0]  k_reg, k_next;
    logic [30:0] t_reg, t_next;
    logic [29:0] x_reg, x_next;
    logic [29:0] est_reg, est_next;
    logic [3:0]  n_reg, n_next;
    logic [30:0] c_reg, c_next;

    logic [31:0] span_w;
    logic [63:0] prod_w;
    logic [60:0] rt_w;
    logic [60:0] xr_w;
    logic [30:0] e_w;

    assign span_w = max_reg - min_reg;
    assign prod_w = {32'b0, rate_reg} * {32'b0, span_w};
    assign rt_w   = 61'(a_reg[29:0]) * 61'(t_reg);
    assign xr_w   = 61'(x_reg) * 61'(RECIP_Q[{2'b0, n_reg}]);
    assign e_w    = t_reg >> k_reg;

    always_comb
    begin
        state_next = state_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        rate_next  = rate_reg;
        span_next  = span_reg;
        err_next   = err_reg;
        a_next     = a_reg;
        k_next     = k_reg;
        t_next     = t_reg;
        x_next     = x_reg;
        est_next   = est_reg;
        n_next     = n_reg;
        c_next     = c_reg;

        case (state_reg)
            CS_SCALE:
            begin
                span_next = span_w;
                err_next  = (rate_reg == 32'd0) || (min_reg >= max_reg);
                if (prod_w[63:2] > {26'b0, A_SAT})
                    a_next = A_SAT;
                else
                    a_next = prod_w[37:2];
                k_next     = 6'd0;
                state_next = CS_REDUCE;
            end
            CS_REDUCE:
            begin
                // peel off whole multiples of ln2
                if (a_reg >= 36'(LN2_Q))
                begin
                    a_next = a_reg - 36'(LN2_Q);
                    k_next = k_reg + 6'd1;
                end
                else
                begin
                    t_next     = QONE;
                    n_next     = EXP_TERMS;
                    state_next = CS_HMUL;
                end
            end
            CS_HMUL:
            begin
                x_next     = rt_w[59:30];
                state_next = CS_HDIV;
            end
            CS_HDIV:
            begin
                est_next   = xr_w[59:30];
                state_next = CS_HFIX;
            end
            CS_HFIX:
            begin
                t_next = QONE - 31'(fix_quot(est_reg, x_reg, {2'b0, n_reg}));
                if (n_reg == 4'd1)
                    state_next = CS_FINISH;
                else
                begin
                    n_next     = n_reg - 4'd1;
                    state_next = CS_HMUL;
                end
            end
            CS_FINISH:
            begin
                c_next     = QONE - e_w;
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase

        // a write restarts the sequencer
        if (cfg_we)
        begin
            state_next = CS_SCALE;
            case (cfg_index)
                REG_MIN:  min_next  = cfg_data;
                REG_MAX:  max_next  = cfg_data;
                REG_RATE: rate_next = cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_SCALE;
            min_reg   <= 32'd0;
            max_reg   <= 32'h0001_0000;
            rate_reg  <= 32'h0001_0000;
        end
        else
        begin
            state_reg <= state_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            rate_reg  <= rate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
        err_reg  <= err_next;
        a_reg    <= a_next;
        k_reg    <= k_next;
        t_reg    <= t_next;
        x_reg    <= x_next;
        est_reg  <= est_next;
        n_reg    <= n_next;
        c_reg    <= c_next;
    end

    assign view.busy        = (state_reg != CS_IDLE);
    assign view.err         = err_reg;
    assign view.min         = min_reg;
    assign view.rate        = rate_reg;
    assign view.span        = span_reg;
    assign view.one_minus_e = c_reg;

endmodule

@@ design/tes_div_pipe.sv @@
// ----------------------------------------------------------------------------
// tes_div_pipe
// Restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module tes_div_pipe (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [tes_pkg::DIV_BITS-1:0]   num,
    input  logic [31:0]                    divisor,
    output logic                           out_valid,
    output logic [tes_pkg::DIV_BITS-1:0]   quot
);
    import tes_pkg::*;

    logic                v_reg   [0:DIV_BITS-1];
    logic [31:0]         rem_reg [0:DIV_BITS-1];
    logic [DIV_BITS-1:0] num_reg [0:DIV_BITS-1];
    logic [DIV_BITS-1:0] q_reg   [0:DIV_BITS-1];

    genvar i;
    generate
        for (i = 0; i < DIV_BITS; i++)
        begin : g_stage
            logic                v_src;
            logic [31:0]         rem_src;
            logic [DIV_BITS-1:0] num_src;
            logic [DIV_BITS-1:0] q_src;
            logic [32:0]         trial;
            logic [32:0]         diff;
            logic                ge;
            logic                v_next;
            logic [31:0]         rem_next;
            logic [DIV_BITS-1:0] num_next;
            logic [DIV_BITS-1:0] q_next;

            if (i == 0)
            begin : g_first
                assign v_src   = in_valid;
                assign rem_src = 32'd0;
                assign num_src = num;
                assign q_src   = '0;
            end
            else
            begin : g_rest
                assign v_src   = v_reg[i-1];
                assign rem_src = rem_reg[i-1];
                assign num_src = num_reg[i-1];
                assign q_src   = q_reg[i-1];
            end

            assign trial    = {rem_src, num_src[DIV_BITS-1]};
            assign diff     = trial - {1'b0, divisor};
            assign ge       = (trial >= {1'b0, divisor});
            assign v_next   = v_src;
            assign rem_next = ge ? diff[31:0] : trial[31:0];
            assign num_next = {num_src[DIV_BITS-2:0], 1'b0};
            assign q_next   = {q_src[DIV_BITS-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (en)
                    v_reg[i] <= v_next;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    num_reg[i] <= num_next;
                    q_reg[i]   <= q_next;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[DIV_BITS-1];
    assign quot      = q_reg[DIV_BITS-1];

endmodule

@@ design/truncated_exponential_sampler.sv @@
// ----------------------------------------------------------------------------
// truncated_exponential_sampler
// Inverse-transform sampler of an exponential distribution truncated to
// [min,max]; unsigned Q16.16 values, Q0.32 uniform input.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; every stage advances together and holds
//   only while the output register is full and stalled.
// After reset, and after every configuration write, the input is stalled
//   while the config sequencer rebuilds 1 - e^(-a).
// Reset: asynchronous, active low; clears all valid bits and loads defaults.
// ----------------------------------------------------------------------------
module truncated_exponential_sampler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] uniform_fraction,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sample_value,
    output logic        config_error
);
    import tes_pkg::*;

    cfg_view_t cfg_view;
    logic      en;
    logic      take;

    // Configuration registers and per-configuration terms
    tes_cfg_unit u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .view      (cfg_view)
    );

    // Advance the whole pipe unless a finished word waits on a stalled sink
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en || cfg_view.busy;
    assign take     = in_valid && !cfg_view.busy;

    // ------------------------------------------------------------------
    // Stage 1: capture u, dropped to Q0.30
    // ------------------------------------------------------------------
    logic        s1_v_reg, s1_v_next;
    logic [29:0] s1_u_reg, s1_u_next;

    assign s1_v_next = take;
    assign s1_u_next = uniform_fraction[31:2];

    // ------------------------------------------------------------------
    // Stage 2: h = u * (1 - E), the amount taken off one
    // ------------------------------------------------------------------
    logic        s2_v_reg, s2_v_next;
    logic [30:0] s2_h_reg, s2_h_next;
    logic [60:0] s2_prod;

    assign s2_prod   = 61'(s1_u_reg) * 61'(cfg_view.one_minus_e);
    assign s2_v_next = s1_v_reg;
    assign s2_h_next = s2_prod[60:30];

    // ------------------------------------------------------------------
    // Stage 3: w = 1 - h, then the coarse normalizing shifts (16, 8).
    // w lies in [2^-30, 1]; exactly one keeps bit 30 set and is not shifted.
    // ------------------------------------------------------------------
    logic        s3_v_reg, s3_v_next;
    logic [30:0] s3_w_reg, s3_w_next;
    logic [4:0]  s3_m_reg, s3_m_next;
    logic [30:0] s3_w0;
    logic [30:0] s3_w1;
    logic        s3_z16;
    logic        s3_z8;

    assign s3_w0     = QONE - s2_h_reg;
    assign s3_z16    = !s3_w0[30] && (s3_w0[29:14] == 16'd0);
    assign s3_w1     = s3_z16 ? (s3_w0 << 16) : s3_w0;
    assign s3_z8     = !s3_w1[30] && (s3_w1[29:22] == 8'd0);
    assign s3_w_next = s3_z8 ? (s3_w1 << 8) : s3_w1;
    assign s3_m_next = {s3_z16, s3_z8, 3'b000};
    assign s3_v_next = s2_v_reg;

    // ------------------------------------------------------------------
    // Stage 4: fine shifts (4, 2, 1) land w in [0.5, 1]; y = 1 - w
    // ------------------------------------------------------------------
    logic        s4_v_reg, s4_v_next;
    logic [29:0] s4_y_reg, s4_y_next;
    logic [4:0]  s4_m_reg, s4_m_next;
    logic [30:0] s4_w1;
    logic [30:0] s4_w2;
    logic [30:0] s4_w3;
    logic [30:0] s4_y;
    logic        s4_z4;
    logic        s4_z2;
    logic        s4_z1;

    assign s4_z4     = !s3_w_reg[30] && (s3_w_reg[29:26] == 4'd0);
    assign s4_w1     = s4_z4 ? (s3_w_reg << 4) : s3_w_reg;
    assign s4_z2     = !s4_w1[30] && (s4_w1[29:28] == 2'd0);
    assign s4_w2     = s4_z2 ? (s4_w1 << 2) : s4_w1;
    assign s4_z1     = !s4_w2[30] && !s4_w2[29];
    assign s4_w3     = s4_z1 ? (s4_w2 << 1) : s4_w2;
    assign s4_y      = QONE - s4_w3;
    assign s4_y_next = s4_y[29:0];
    assign s4_m_next = s3_m_reg + {2'b00, s4_z4, s4_z2, s4_z1};
    assign s4_v_next = s3_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
            s3_v_reg <= s3_v_next;
            s4_v_reg <= s4_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_u_reg <= s1_u_next;
            s2_h_reg <= s2_h_next;
            s3_w_reg <= s3_w_next;
            s3_m_reg <= s3_m_next;
            s4_y_reg <= s4_y_next;
            s4_m_reg <= s4_m_next;
        end
    end

    // ------------------------------------------------------------------
    // Series stages: -ln(1 - y) = sum y^n / n, one term per stage.
    // Stage n forms y^(n+1) and a reciprocal estimate of y^n / n; the
    // estimate is corrected and added to the sum one stage later.
    // ------------------------------------------------------------------
    logic        t_v_reg   [1:LOG_TERMS];
    logic [29:0] t_p_reg   [1:LOG_TERMS];
    logic [29:0] t_y_reg   [1:LOG_TERMS];
    logic [4:0]  t_m_reg   [1:LOG_TERMS];
    logic [30:0] t_acc_reg [1:LOG_TERMS];
    logic [29:0] t_est_reg [1:LOG_TERMS];
    logic [29:0] t_pq_reg  [1:LOG_TERMS];

    genvar j;
    generate
        for (j = 1; j <= LOG_TERMS; j++)
        begin : g_term
            logic        v_src;
            logic [29:0] p_src;
            logic [29:0] y_src;
            logic [4:0]  m_src;
            logic [30:0] acc_src;
            logic [29:0] term;
            logic [59:0] py;
            logic [60:0] pr;
            logic [30:0] acc_next;

            if (j == 1)
            begin : g_first
                assign v_src   = s4_v_reg;
                assign p_src   = s4_y_reg;
                assign y_src   = s4_y_reg;
                assign m_src   = s4_m_reg;
                assign acc_src = 31'd0;
                assign term    = 30'd0;
            end
            else
            begin : g_rest
                assign v_src   = t_v_reg[j-1];
                assign p_src   = t_p_reg[j-1];
                assign y_src   = t_y_reg[j-1];
                assign m_src   = t_m_reg[j-1];
                assign acc_src = t_acc_reg[j-1];
                assign term    = fix_quot(t_est_reg[j-1], t_pq_reg[j-1], 6'(j - 1));
            end

            assign py       = 60'(p_src) * 60'(y_src);
            assign pr       = 61'(p_src) * 61'(RECIP_Q[j]);
            assign acc_next = acc_src + 31'(term);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    t_v_reg[j] <= 1'b0;
                else if (en)
                    t_v_reg[j] <= v_src;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    t_p_reg[j]   <= py[59:30];
                    t_y_reg[j]   <= y_src;
                    t_m_reg[j]   <= m_src;
                    t_acc_reg[j] <= acc_next;
                    t_est_reg[j] <= pr[59:30];
                    t_pq_reg[j]  <= p_src;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Log stage: L = m * ln2 + series sum, closing the last term
    // ------------------------------------------------------------------
    logic        l_v_reg, l_v_next;
    logic [35:0] l_val_reg, l_val_next;
    logic [29:0] l_last;

    assign l_last     = fix_quot(t_est_reg[LOG_TERMS], t_pq_reg[LOG_TERMS], 6'(LOG_TERMS));
    assign l_val_next = 36'(t_m_reg[LOG_TERMS]) * 36'(LN2_Q)
                      + 36'(t_acc_reg[LOG_TERMS]) + 36'(l_last);
    assign l_v_next   = t_v_reg[LOG_TERMS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            l_v_reg <= 1'b0;
        else if (en)
            l_v_reg <= l_v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            l_val_reg <= l_val_next;
    end

    // ------------------------------------------------------------------
    // Offset = floor(L * 4 / rate): Q.30 times 2^16 over a Q16.16 rate
    // ------------------------------------------------------------------
    logic                d_valid;
    logic [DIV_BITS-1:0] d_quot;

    tes_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (l_v_reg),
        .num       ({l_val_reg, 2'b00}),
        .divisor   (cfg_view.rate),
        .out_valid (d_valid),
        .quot      (d_quot)
    );

    // ------------------------------------------------------------------
    // Output register: clamp offset to the span, add min, or flag a bad
    // configuration with a zero sample
    // ------------------------------------------------------------------
    logic        out_valid_reg, out_valid_next;
    logic [31:0] sample_reg, sample_next;
    logic        error_reg, error_next;
    logic [31:0] offset;

    assign offset         = (d_quot > {6'b0, cfg_view.span}) ? cfg_view.span
                                                             : d_quot[31:0];
    assign sample_next    = cfg_view.err ? 32'd0 : (cfg_view.min + offset);
    assign error_next     = cfg_view.err;
    assign out_valid_next = d_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_reg <= sample_next;
            error_reg  <= error_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = sample_reg;
    assign config_error = error_reg;

endmodule

@@ dv/tes_checker.sv @@
// ----------------------------------------------------------------------------
// tes_checker
// Watches the configuration port and both word channels of the truncated
// exponential sampler, predicts each output word and compares it.
// ----------------------------------------------------------------------------
module tes_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] uniform_fraction,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] sample_value,
    input  logic        config_error,
    output int          fail_count,
    output int          pending_words,
    output int          checked_words,
    output int          error_words
);
    import tes_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int UNI_BITS  = 32;
    localparam int Q         = 30;
    localparam logic [63:0] ONE_Q = 64'd1 << Q;
    localparam logic [63:0] LN2   = 64'd744261118;

    typedef struct packed {
        logic [31:0] sample;
        logic        err;
    } sample_word_t;

    logic [31:0] lo_bound, hi_bound, lambda;
    sample_word_t sample_queue[$];

    // e^-a, a in Q.30 up to 32.0
    function automatic logic [63:0] decay(input logic [63:0] a);
        logic [63:0] k, r, t;
        k = a / LN2;
        r = a - k * LN2;
        t = ONE_Q;
        for (int n = 12; n >= 1; n--)
            t = ONE_Q - ((r * t) >> Q) / n;
        if (k >= 63)
            return 0;
        return t >> k;
    endfunction

    // -ln w, w in Q0.30
    function automatic logic [63:0] neg_ln(input logic [63:0] w);
        logic [63:0] m, y, p, acc;
        m = 0;
        acc = 0;
        while (w < (ONE_Q >> 1))
        begin
            w = w << 1;
            m++;
        end
        y = ONE_Q - w;
        p = y;
        for (int n = 1; n <= 32; n++)
        begin
            acc += p / n;
            p = (p * y) >> Q;
        end
        return m * LN2 + acc;
    endfunction

    function automatic sample_word_t predict_sample(input logic [31:0] u_in);
        sample_word_t res;
        logic [63:0] u30, span, a, e, w, l, q, r, den;
        int sh;
        res = '0;
        if (lambda == 0 || lo_bound >= hi_bound)
        begin
            res.err = 1'b1;
            return res;
        end
        u30  = 64'(u_in) >> (UNI_BITS - Q);
        span = 64'(hi_bound - lo_bound);
        sh   = 2 * FRAC_BITS - Q;
        a    = (64'(lambda) * span) >> sh;
        if (a > (64'd32 << Q))
            a = 64'd32 << Q;
        e = decay(a);
        w = ONE_Q - ((u30 * (ONE_Q - e)) >> Q);
        l = neg_ln(w);
        // floor(l * 2^sh / rate), clamped to span
        den = 64'(lambda);
        q = l / den;
        r = l % den;
        if (q > span)
            q = span;
        else
            for (int i = 0; i < sh; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r -= den;
                    q[0] = 1'b1;
                end
                if (q > span)
                begin
                    q = span;
                    break;
                end
            end
        res.sample = lo_bound + q[31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h (word %0d)", what, got, want,
                 checked_words);
        fail_count++;
    endtask

    // track the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_bound <= 32'd0;
            hi_bound <= 32'h0001_0000;
            lambda   <= 32'h0001_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN:  lo_bound <= cfg_data;
                REG_MAX:  hi_bound <= cfg_data;
                REG_RATE: lambda   <= cfg_data;
                default: ;
            endcase
        end
    end

    initial
    begin
        fail_count    = 0;
        checked_words = 0;
        error_words   = 0;
    end

    assign pending_words = sample_queue.size();

    always @(posedge clk)
    begin
        sample_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (sample_queue.size() == 0)
                begin
                    report_mismatch("unexpected word", sample_value, 32'd0);
                end
                else
                begin
                    want = sample_queue.pop_front();
                    if (sample_value !== want.sample)
                        report_mismatch("sample_value", sample_value, want.sample);
                    if (config_error !== want.err)
                        report_mismatch("config_error", 32'(config_error),
                                        32'(want.err));
                    if (want.err)
                        error_words++;
                    checked_words++;
                end
            end
            if (in_valid && !in_stall)
                sample_queue.push_back(predict_sample(uniform_fraction));
        end
    end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the truncated exponential sampler through a series of bound and rate
// settings, with directed and random uniform words and random gaps on both
// channels; a checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module testbench;
    import tes_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 120;
    localparam int NUM_PHASES   = 12;
    localparam int RANDOM_WORDS = 130;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] uniform_fraction;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] sample_value;
    logic        config_error;

    int fail_count, pending_words, checked_words, error_words;
    int idle_cycles;
    int sent_words;
    bit quiet_mode;   // when set, neither side inserts gaps

    truncated_exponential_sampler u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .uniform_fraction (uniform_fraction),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sample_value     (sample_value),
        .config_error     (config_error)
    );

    tes_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .uniform_fraction (uniform_fraction),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sample_value     (sample_value),
        .config_error     (config_error),
        .fail_count       (fail_count),
        .pending_words    (pending_words),
        .checked_words    (checked_words),
        .error_words      (error_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: draw a stall length per word, then wait for the word to move.
    initial
    begin
        int n;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            n = quiet_mode ? 0 : $urandom_range(0, 13);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Send one word: hold valid until accepted; optional gap first.
    task automatic send_word(input logic [31:0] u);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        uniform_fraction <= u;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_words++;
    endtask

    // Drop valid and wait until every predicted word has come back.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_bounds(input logic [31:0] lo, input logic [31:0] hi,
                                input logic [31:0] lam);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_MAX;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= REG_RATE;
        cfg_data  <= lam;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly full-range words, plus the corners and very small/large fractions.
    function automatic logic [31:0] random_fraction;
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 255);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            2: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [31:0] lo, hi, lam;
        logic [31:0] corner_words[5];
        corner_words = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000, 32'h4000_0000};

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= REG_MIN;
        cfg_data         <= 32'd0;
        in_valid         <= 1'b0;
        uniform_fraction <= 32'd0;
        sent_words       = 0;
        quiet_mode       = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // Pick the setting; phase 0 keeps the reset defaults.
            case (ph)
                0: ;
                1: begin lo = 32'd0;          hi = 32'hFFFF_FFFF; lam = 32'd1;          end
                2: begin lo = 32'd0;          hi = 32'hFFFF_FFFF; lam = 32'hFFFF_FFFF;  end
                3: begin lo = 32'hFFFF_FFFE;  hi = 32'hFFFF_FFFF; lam = 32'hFFFF_FFFF;  end
                4: begin lo = 32'h0001_0000;  hi = 32'h0003_0000; lam = 32'd0;          end
                5: begin lo = 32'h0005_0000;  hi = 32'h0005_0000; lam = 32'h0001_0000;  end
                6: begin lo = 32'hFFFF_FFFF;  hi = 32'd0;         lam = 32'h0002_0000;  end
                7: begin lo = 32'h0000_8000;  hi = 32'h0100_0000; lam = 32'h0000_0100;  end
                8, 9:
                begin
                    // fully random bits for bounds and rate
                    lo = $urandom; hi = $urandom; lam = $urandom;
                end
                default:
                begin
                    lo  = $urandom_range(0, 32'h00FF_FFFF);
                    hi  = lo + $urandom_range(1, 32'h0100_0000);
                    lam = $urandom_range(1, 32'h0010_0000);
                end
            endcase
            if (ph != 0)
                write_bounds(lo, hi, lam);

            quiet_mode = (ph % 4 == 3);

            // Corner fractions on phases 0 to 4
            if (ph < 5)
                foreach (corner_words[i])
                    send_word(corner_words[i]);

            for (int i = 0; i < RANDOM_WORDS; i++)
                send_word(random_fraction());

            // Hold off until every expected word has come back.
            drain();
        end

        $display("covered %0d settings, %0d words sent, %0d checked, %0d flagged bad config",
                 NUM_PHASES, sent_words, checked_words, error_words);
        if (fail_count == 0 && pending_words == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
